### rtl/cmct_pkg.sv
// Shared types and constants for the complex matrix chain trace core.
// No dependencies; imported by cmct_mac and complex_matrix_chain_trace_core.
package cmct_pkg;

  localparam int PROD_W = 64;   // exact 32x32 signed product
  localparam int ACC_W  = 72;   // exact sum of up to 128 products

  typedef enum logic [1:0] {
    REQ_LOAD_C  = 2'd0,
    REQ_LOAD_M  = 2'd1,
    REQ_LOAD_DM = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_t;

  localparam logic CFG_STATES = 1'b0;
  localparam logic CFG_BEADS  = 1'b1;

  // Control word from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;    // zero both accumulators
    logic mul;    // register a * b
    logic acc;    // fold the product into an accumulator
    logic sub;    // subtract instead of add
    logic to_im;  // target the imaginary accumulator
  } mac_ctl_t;

endpackage

### rtl/cmct_mem.sv
// Matrix store: one write port, two registered read ports.
// Depends on nothing; used by complex_matrix_chain_trace_core.
module cmct_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [63:0]   rdata_a,
  output logic [63:0]   rdata_b
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/cmct_mac.sv
// Shared multiply-accumulate unit: one 32x32 signed multiplier, product
// register and two exact wide accumulators. Depends on cmct_pkg.
module cmct_mac (
  input  logic                                clk,
  input  cmct_pkg::mac_ctl_t                  ctl,
  input  logic signed [31:0]                  a,
  input  logic signed [31:0]                  b,
  output logic signed [cmct_pkg::ACC_W-1:0]   acc_re,
  output logic signed [cmct_pkg::ACC_W-1:0]   acc_im
);
  import cmct_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  term;

  assign prod_x = ACC_W'(prod);
  assign term   = ctl.sub ? -prod_x : prod_x;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
    if (ctl.clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (ctl.acc) begin
      if (ctl.to_im) begin
        acc_im <= acc_im + term;
      end else begin
        acc_re <= acc_re + term;
      end
    end
  end

endmodule

### rtl/complex_matrix_chain_trace_core.sv
// Top level of the complex matrix chain trace core: sequencer, operand
// selection, saturation and handshakes. Depends on cmct_pkg, cmct_mem, cmct_mac.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tuser req_type, s_tdata element load
//  m_*       out  m_tvalid / m_tready  m_tdata theta_deriv, overflow
//  cfg_*     in   cfg_we               cfg_addr register index, cfg_wdata value
//
// A valid load word is written as it is accepted. A compute word runs 2 * (nb - 1)
// matrix products forward, the same backward and nb products plus nb traces,
// all through the one shared multiplier. s_tready is high only while the
// sequencer is idle. The result sits in an output register; a compute
// finishing while an earlier result is still untaken holds until it leaves.
// rst clears control state and restores states_used = min(MAX_STATES, 4) and
// beads_used = min(MAX_BEADS, 16).
module complex_matrix_chain_trace_core #(
  parameter int MAX_STATES = 4,
  parameter int MAX_BEADS  = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // bead_index[3:0], row_index[5:4], col_index[7:6],
                                 // value_re[39:8], value_im[71:40]
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // theta_deriv[47:0], overflow[48], zero pad
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_wdata
);
  import cmct_pkg::*;

  localparam int SW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int BW    = (MAX_BEADS > 1) ? $clog2(MAX_BEADS) : 1;
  localparam int NW    = $clog2(MAX_STATES + 1);
  localparam int NBW   = $clog2(MAX_BEADS + 1);
  localparam int CW    = NW + 1;
  localparam int CBW   = NBW + 1;
  localparam int NSLOT = 3 * MAX_BEADS + 3;
  localparam int SLW   = $clog2(NSLOT);
  localparam int AW    = SLW + 2 * SW;
  localparam int DEPTH = NSLOT * (1 << (2 * SW));
  localparam int SLOT_F  = MAX_BEADS;
  localparam int SLOT_B  = 2 * MAX_BEADS;
  localparam int SLOT_M  = 3 * MAX_BEADS;
  localparam int SLOT_DM = 3 * MAX_BEADS + 1;
  localparam int SLOT_T  = 3 * MAX_BEADS + 2;

  localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] S32_MIN = ACC_W'(-64'sd2147483648);
  localparam logic signed [ACC_W:0]   S48_MAX = (ACC_W+1)'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [ACC_W:0]   S48_MIN = -S48_MAX - (ACC_W+1)'(1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ADDR = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_WB   = 7'b0010000,
    ST_TSUM = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_FWD = 3'b001,
    PH_BWD = 3'b010,
    PH_TRC = 3'b100
  } phase_t;

  state_t           state;
  phase_t           phase;
  logic             half;           // 0: product into scratch, 1: chain step
  logic [BW-1:0]    bead;
  logic [SW-1:0]    i, j, k;
  logic [1:0]       p;
  logic [NW-1:0]    n_reg;
  logic [NBW-1:0]   nb_reg;
  logic             ovf;
  logic signed [47:0] sum;
  logic             out_valid;
  logic [48:0]      out_data;

  // Input word fields
  logic [3:0]  in_bead;
  logic [1:0]  in_row, in_col;
  logic [31:0] in_re, in_im;
  assign in_bead = s_tdata[3:0];
  assign in_row  = s_tdata[5:4];
  assign in_col  = s_tdata[7:6];
  assign in_re   = s_tdata[39:8];
  assign in_im   = s_tdata[71:40];

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_data};

  // Loop bounds
  logic k_last, i_last, j_last, b_last, b_zero, trace_mode, p_last;
  assign k_last     = (CW'(k) + CW'(1)) == CW'(n_reg);
  assign i_last     = (CW'(i) + CW'(1)) == CW'(n_reg);
  assign j_last     = (CW'(j) + CW'(1)) == CW'(n_reg);
  assign b_last     = (CBW'(bead) + CBW'(1)) == CBW'(nb_reg);
  assign b_zero     = (bead == '0);
  assign trace_mode = (phase == PH_TRC) && half;
  assign p_last     = trace_mode ? (p == 2'd1) : (p == 2'd3);

  // Forward source: bead 0 is C0 itself; backward source past the end is I.
  function automatic logic [SLW-1:0] f_slot(input logic [BW-1:0] x);
    f_slot = (x == '0) ? SLW'(0) : SLW'(SLOT_F) + SLW'(x);
  endfunction

  logic [BW-1:0]  bead_prev, bead_succ;
  logic           succ_is_end;
  assign bead_prev   = bead - BW'(1);
  assign bead_succ   = bead + BW'(1);
  assign succ_is_end = (CBW'(bead) + CBW'(2)) == CBW'(nb_reg);

  logic [SLW-1:0] slot_a, slot_b, slot_d;
  logic           b_ident;

  always_comb begin
    slot_a  = SLW'(SLOT_M);
    slot_b  = SLW'(SLOT_T);
    slot_d  = SLW'(SLOT_T);
    b_ident = 1'b0;
    unique case (phase)
      PH_FWD: begin
        if (!half) begin
          slot_a = SLW'(SLOT_M);
          slot_b = SLW'(bead);
        end else begin
          slot_a = f_slot(bead_prev);
          slot_b = SLW'(SLOT_T);
          slot_d = SLW'(SLOT_F) + SLW'(bead);
        end
      end
      PH_BWD: begin
        if (!half) begin
          slot_a = SLW'(bead_succ);
          slot_b = SLW'(SLOT_M);
        end else begin
          slot_a  = SLW'(SLOT_T);
          slot_b  = SLW'(SLOT_B) + SLW'(bead_succ);
          b_ident = succ_is_end;
          slot_d  = SLW'(SLOT_B) + SLW'(bead);
        end
      end
      PH_TRC: begin
        if (!half) begin
          slot_a = f_slot(bead);
          slot_b = SLW'(SLOT_DM);
        end else begin
          slot_a  = SLW'(SLOT_T);
          slot_b  = SLW'(SLOT_B) + SLW'(bead);
          b_ident = b_last;
        end
      end
      default: ;
    endcase
  end

  // Read addresses: A at (i,k); B at (k,j), or (k,i) while tracing.
  logic [SW-1:0] b_col;
  logic [AW-1:0] raddr_a, raddr_b;
  assign b_col   = trace_mode ? i : j;
  assign raddr_a = {slot_a, i, k};
  assign raddr_b = {slot_b, k, b_col};

  // Load and write-back port
  logic        ld_ok, ld_we, wb_we;
  logic [SW-1:0] ld_row, ld_col;
  logic [SLW-1:0] ld_slot;
  logic [AW-1:0]  waddr;
  logic [63:0]    wdata;

  assign ld_row = SW'(in_row);
  assign ld_col = SW'(in_col);
  assign ld_ok  = (32'(in_row) < 32'(MAX_STATES)) && (32'(in_col) < 32'(MAX_STATES)) &&
                  ((s_tuser != REQ_LOAD_C) || (32'(in_bead) < 32'(MAX_BEADS)));

  always_comb begin
    unique case (s_tuser)
      REQ_LOAD_C:  ld_slot = SLW'(in_bead);
      REQ_LOAD_M:  ld_slot = SLW'(SLOT_M);
      REQ_LOAD_DM: ld_slot = SLW'(SLOT_DM);
      default:     ld_slot = SLW'(SLOT_M);
    endcase
  end

  assign ld_we = s_tvalid && s_tready && (s_tuser != REQ_COMPUTE) && ld_ok;
  assign wb_we = (state == ST_WB);

  logic [63:0] rdata_a, rdata_b;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic signed [ACC_W-1:0] fl_re, fl_im;
  logic [31:0] sat_re, sat_im;
  logic        ovf_re, ovf_im;

  // Element result: floor of the exact sum, saturated per part.
  assign fl_re = acc_re >>> FRAC_BITS;
  assign fl_im = acc_im >>> FRAC_BITS;

  always_comb begin
    ovf_re = 1'b1;
    ovf_im = 1'b1;
    priority if (fl_re > S32_MAX) sat_re = 32'h7FFF_FFFF;
    else if (fl_re < S32_MIN)     sat_re = 32'h8000_0000;
    else begin
      sat_re = fl_re[31:0];
      ovf_re = 1'b0;
    end
    priority if (fl_im > S32_MAX) sat_im = 32'h7FFF_FFFF;
    else if (fl_im < S32_MIN)     sat_im = 32'h8000_0000;
    else begin
      sat_im = fl_im[31:0];
      ovf_im = 1'b0;
    end
  end

  assign waddr = wb_we ? {slot_d, i, j} : {ld_slot, ld_row, ld_col};
  assign wdata = wb_we ? {sat_re, sat_im} : {in_re, in_im};

  cmct_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (ld_we || wb_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Operand selection for the shared multiplier
  logic signed [31:0] ar, ai, br, bi, op_a, op_b;
  logic               diag;
  assign diag = (k == b_col);
  assign ar   = rdata_a[63:32];
  assign ai   = rdata_a[31:0];
  assign br   = b_ident ? (diag ? (32'd1 << FRAC_BITS) : 32'd0) : rdata_b[63:32];
  assign bi   = b_ident ? 32'd0 : rdata_b[31:0];
  assign op_a = (p == 2'd0 || p == 2'd2) ? ar : ai;
  assign op_b = (p == 2'd0 || p == 2'd3) ? br : bi;

  mac_ctl_t mac_ctl;
  always_comb begin
    mac_ctl.clr   = (state == ST_IDLE) || (state == ST_WB) || (state == ST_TSUM);
    mac_ctl.mul   = (state == ST_MUL);
    mac_ctl.acc   = (state == ST_ACC);
    mac_ctl.sub   = (p == 2'd1);
    mac_ctl.to_im = p[1];
  end

  cmct_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .a      (op_a),
    .b      (op_b),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  // Running trace sum, saturated to 48 bits after every bead
  logic signed [ACC_W:0] sum_wide;
  logic signed [47:0]    sum_next;
  logic                  sum_ovf;
  assign sum_wide = (ACC_W+1)'(sum) + (ACC_W+1)'(fl_re);

  always_comb begin
    sum_ovf = 1'b1;
    priority if (sum_wide > S48_MAX) sum_next = 48'sh7FFF_FFFF_FFFF;
    else if (sum_wide < S48_MIN)     sum_next = 48'sh8000_0000_0000;
    else begin
      sum_next = sum_wide[47:0];
      sum_ovf  = 1'b0;
    end
  end

  // Where to go once a product or a trace is finished
  phase_t        op_phase;
  logic          op_half;
  logic [BW-1:0] op_bead;
  state_t        op_state;

  always_comb begin
    op_phase = phase;
    op_half  = ~half;
    op_bead  = bead;
    op_state = ST_ADDR;
    if (half) begin
      unique case (phase)
        PH_FWD: begin
          if (b_last) begin
            op_phase = PH_BWD;
            op_bead  = BW'(nb_reg - NBW'(2));
          end else begin
            op_bead = bead_succ;
          end
        end
        PH_BWD: begin
          if (b_zero) begin
            op_phase = PH_TRC;
            op_bead  = '0;
          end else begin
            op_bead = bead_prev;
          end
        end
        PH_TRC: begin
          if (b_last) begin
            op_state = ST_DONE;
          end else begin
            op_bead = bead_succ;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_FWD;
      half      <= 1'b0;
      bead      <= '0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      p         <= '0;
      n_reg     <= NW'(MAX_STATES < 4 ? MAX_STATES : 4);
      nb_reg    <= NBW'(MAX_BEADS < 16 ? MAX_BEADS : 16);
      ovf       <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Clamp register writes into 1..MAX
      if (cfg_we) begin
        if (cfg_addr == CFG_STATES) begin
          if (cfg_wdata[2:0] == 3'd0)                   n_reg <= NW'(1);
          else if (32'(cfg_wdata[2:0]) > 32'(MAX_STATES)) n_reg <= NW'(MAX_STATES);
          else                                          n_reg <= NW'(cfg_wdata[2:0]);
        end else begin
          if (cfg_wdata == 5'd0)                        nb_reg <= NBW'(1);
          else if (32'(cfg_wdata) > 32'(MAX_BEADS))     nb_reg <= NBW'(MAX_BEADS);
          else                                          nb_reg <= NBW'(cfg_wdata);
        end
      end

      // Drop a taken result word; ST_DONE refills the register itself
      if (out_valid && m_tready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tuser == REQ_COMPUTE) begin
            ovf  <= 1'b0;
            sum  <= '0;
            half <= 1'b0;
            i    <= '0;
            j    <= '0;
            k    <= '0;
            p    <= '0;
            if (nb_reg == NBW'(1)) begin
              phase <= PH_TRC;
              bead  <= '0;
            end else begin
              phase <= PH_FWD;
              bead  <= BW'(1);
            end
            state <= ST_ADDR;
          end
        end
        ST_ADDR: state <= ST_MUL;
        ST_MUL:  state <= ST_ACC;
        ST_ACC: begin
          if (!p_last) begin
            p     <= p + 2'd1;
            state <= ST_MUL;
          end else begin
            p <= '0;
            if (!k_last) begin
              k     <= k + SW'(1);
              state <= ST_ADDR;
            end else if (trace_mode) begin
              k <= '0;
              if (!i_last) begin
                i     <= i + SW'(1);
                state <= ST_ADDR;
              end else begin
                state <= ST_TSUM;
              end
            end else begin
              state <= ST_WB;
            end
          end
        end
        ST_WB: begin
          // Store the element, then step to the next one or the next product
          k <= '0;
          if (ovf_re || ovf_im) ovf <= 1'b1;
          if (!j_last) begin
            j     <= j + SW'(1);
            state <= ST_ADDR;
          end else begin
            j <= '0;
            if (!i_last) begin
              i     <= i + SW'(1);
              state <= ST_ADDR;
            end else begin
              i     <= '0;
              phase <= op_phase;
              half  <= op_half;
              bead  <= op_bead;
              state <= op_state;
            end
          end
        end
        ST_TSUM: begin
          sum <= sum_next;
          if (sum_ovf) ovf <= 1'b1;
          i     <= '0;
          phase <= op_phase;
          half  <= op_half;
          bead  <= op_bead;
          state <= op_state;
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid || m_tready) begin
            out_data  <= {ovf, sum};
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
